>>> src/segx_pkg.sv
// Shared widths and status codes for the segment crossing core.
package segx_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int DET_BITS   = PROD_BITS + 1;
    localparam int LO_BITS    = DET_BITS / 2 + 1;
    localparam int HI_BITS    = DET_BITS - LO_BITS;
    localparam int PLO_BITS   = LO_BITS + 1 + DIFF_BITS;
    localparam int PHI_BITS   = HI_BITS + DIFF_BITS;
    localparam int PR_BITS    = DET_BITS + DIFF_BITS;
    localparam int NUM_BITS   = PR_BITS + 2;
    localparam int DEN_BITS   = DET_BITS + 1;
    localparam int QUO_BITS   = COORD_BITS + 1;

    localparam int DIV_FIRST  = 7;
    localparam int DIV_LAST   = DIV_FIRST + QUO_BITS - 1;
    localparam int NUM_STAGES = DIV_LAST + 1;

    typedef enum logic [1:0] {
        STAT_CROSS    = 2'd0,
        STAT_PARALLEL = 2'd1,
        STAT_OUTSIDE  = 2'd2
    } status_t;

endpackage

>>> src/segment_intersection_core.sv
// Segment crossing core: determinant, range tests, pipelined rounding divider.
// Throughput: one request per cycle; each stage holds its item until the next frees up.
// The divider produces one quotient bit per stage (25 stages per axis).
// Reset (rst_n low, asynchronous): all stage valid bits clear, no result pending.
// Datapath registers are not reset.
module segment_intersection_core
    import segx_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] seg_a_start_x,
    input  logic signed [COORD_BITS-1:0] seg_a_start_y,
    input  logic signed [COORD_BITS-1:0] seg_a_end_x,
    input  logic signed [COORD_BITS-1:0] seg_a_end_y,
    input  logic signed [COORD_BITS-1:0] seg_b_start_x,
    input  logic signed [COORD_BITS-1:0] seg_b_start_y,
    input  logic signed [COORD_BITS-1:0] seg_b_end_x,
    input  logic signed [COORD_BITS-1:0] seg_b_end_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS-1:0] cross_x,
    output logic signed [COORD_BITS-1:0] cross_y,
    output logic [1:0]                   cross_status
);

    logic [NUM_STAGES:1] vld_reg;
    logic [NUM_STAGES:1] en;

    // stage 1: differences
    logic signed [DIFF_BITS-1:0] dx12_reg, dy12_reg, dx34_reg, dy34_reg;
    logic signed [DIFF_BITS-1:0] dx13_reg, dy13_reg;
    logic signed [DIFF_BITS-1:0] delx_reg [1:5];
    logic signed [DIFF_BITS-1:0] dely_reg [1:5];
    logic signed [COORD_BITS-1:0] x1_reg [1:DIV_LAST];
    logic signed [COORD_BITS-1:0] y1_reg [1:DIV_LAST];

    // stage 2: products
    logic signed [PROD_BITS-1:0] pd0_reg, pd1_reg, pt0_reg, pt1_reg, pu0_reg, pu1_reg;

    // stage 3: determinant and numerators
    logic signed [DET_BITS-1:0] det_reg, tn_reg, un_reg;

    // stage 4: status, partial products of tn * delta
    status_t                    stat_reg [4:DIV_LAST];
    logic [DET_BITS-1:0]        dabs_reg [4:5];
    logic                       dneg_reg [4:5];
    logic signed [PLO_BITS-1:0] plox_reg, ploy_reg;
    logic signed [PHI_BITS-1:0] phix_reg, phiy_reg;

    // stage 5: full products
    logic signed [PR_BITS-1:0]  px_reg, py_reg;

    // stage 6 and divider
    logic [DEN_BITS-1:0]  den_reg  [6:DIV_LAST];
    logic                 negx_reg [6:DIV_LAST];
    logic                 negy_reg [6:DIV_LAST];
    logic [NUM_BITS-1:0]  remx_reg [6:DIV_LAST];
    logic [NUM_BITS-1:0]  remy_reg [6:DIV_LAST];
    logic [QUO_BITS-1:0]  qx_reg   [6:DIV_LAST];
    logic [QUO_BITS-1:0]  qy_reg   [6:DIV_LAST];

    // output
    logic signed [COORD_BITS-1:0] cross_x_reg, cross_y_reg;
    status_t                      cross_status_reg;
    logic signed [COORD_BITS-1:0] cross_x_next, cross_y_next;

    function automatic logic in_unit(input logic signed [DET_BITS-1:0] n,
                                     input logic signed [DET_BITS-1:0] d);
        logic signed [DET_BITS:0] nn;
        logic signed [DET_BITS:0] dd;
        nn = (DET_BITS+1)'(n);
        dd = (DET_BITS+1)'(d);
        if (dd < 0)
        begin
            nn = -nn;
            dd = -dd;
        end
        return !nn[DET_BITS] && (nn <= dd);
    endfunction

    // each slot loads when empty or when its holder moves on
    always_comb
    begin
        en[NUM_STAGES] = !vld_reg[NUM_STAGES] || out_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stages 1 to 6
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dx12_reg   <= DIFF_BITS'(seg_a_start_x) - DIFF_BITS'(seg_a_end_x);
            dy12_reg   <= DIFF_BITS'(seg_a_start_y) - DIFF_BITS'(seg_a_end_y);
            dx34_reg   <= DIFF_BITS'(seg_b_start_x) - DIFF_BITS'(seg_b_end_x);
            dy34_reg   <= DIFF_BITS'(seg_b_start_y) - DIFF_BITS'(seg_b_end_y);
            dx13_reg   <= DIFF_BITS'(seg_a_start_x) - DIFF_BITS'(seg_b_start_x);
            dy13_reg   <= DIFF_BITS'(seg_a_start_y) - DIFF_BITS'(seg_b_start_y);
            delx_reg[1] <= DIFF_BITS'(seg_a_end_x) - DIFF_BITS'(seg_a_start_x);
            dely_reg[1] <= DIFF_BITS'(seg_a_end_y) - DIFF_BITS'(seg_a_start_y);
            x1_reg[1]  <= seg_a_start_x;
            y1_reg[1]  <= seg_a_start_y;
        end
        for (int k = 2; k <= DIV_LAST; k++)
        begin
            if (en[k])
            begin
                x1_reg[k] <= x1_reg[k-1];
                y1_reg[k] <= y1_reg[k-1];
            end
        end
        for (int k = 2; k <= 5; k++)
        begin
            if (en[k])
            begin
                delx_reg[k] <= delx_reg[k-1];
                dely_reg[k] <= dely_reg[k-1];
            end
        end
        if (en[2])
        begin
            pd0_reg <= PROD_BITS'(dx12_reg) * PROD_BITS'(dy34_reg);
            pd1_reg <= PROD_BITS'(dy12_reg) * PROD_BITS'(dx34_reg);
            pt0_reg <= PROD_BITS'(dx13_reg) * PROD_BITS'(dy34_reg);
            pt1_reg <= PROD_BITS'(dy13_reg) * PROD_BITS'(dx34_reg);
            pu0_reg <= PROD_BITS'(dy12_reg) * PROD_BITS'(dx13_reg);
            pu1_reg <= PROD_BITS'(dx12_reg) * PROD_BITS'(dy13_reg);
        end
        if (en[3])
        begin
            det_reg <= DET_BITS'(pd0_reg) - DET_BITS'(pd1_reg);
            tn_reg  <= DET_BITS'(pt0_reg) - DET_BITS'(pt1_reg);
            un_reg  <= DET_BITS'(pu0_reg) - DET_BITS'(pu1_reg);
        end
        if (en[4])
        begin
            if (det_reg == '0)
                stat_reg[4] <= STAT_PARALLEL;
            else if (!in_unit(tn_reg, det_reg) || !in_unit(un_reg, det_reg))
                stat_reg[4] <= STAT_OUTSIDE;
            else
                stat_reg[4] <= STAT_CROSS;
            dabs_reg[4] <= (det_reg < 0) ? DET_BITS'(-det_reg) : DET_BITS'(det_reg);
            dneg_reg[4] <= det_reg[DET_BITS-1];
            // tn split into an unsigned low half and a signed high half
            plox_reg <= PLO_BITS'($signed({1'b0, tn_reg[LO_BITS-1:0]}))
                        * PLO_BITS'(delx_reg[3]);
            ploy_reg <= PLO_BITS'($signed({1'b0, tn_reg[LO_BITS-1:0]}))
                        * PLO_BITS'(dely_reg[3]);
            phix_reg <= PHI_BITS'($signed(tn_reg[DET_BITS-1:LO_BITS]))
                        * PHI_BITS'(delx_reg[3]);
            phiy_reg <= PHI_BITS'($signed(tn_reg[DET_BITS-1:LO_BITS]))
                        * PHI_BITS'(dely_reg[3]);
        end
        for (int k = 5; k <= DIV_LAST; k++)
        begin
            if (en[k])
            begin
                stat_reg[k] <= stat_reg[k-1];
            end
        end
        if (en[5])
        begin
            dabs_reg[5] <= dabs_reg[4];
            dneg_reg[5] <= dneg_reg[4];
            px_reg <= (PR_BITS'(phix_reg) <<< LO_BITS) + PR_BITS'(plox_reg);
            py_reg <= (PR_BITS'(phiy_reg) <<< LO_BITS) + PR_BITS'(ploy_reg);
        end
        if (en[6])
        begin
            // rounded quotient: (2|p| + |d|) / (2|d|)
            remx_reg[6] <= (NUM_BITS'(px_reg < 0 ? -px_reg : px_reg) << 1)
                           + NUM_BITS'(dabs_reg[5]);
            remy_reg[6] <= (NUM_BITS'(py_reg < 0 ? -py_reg : py_reg) << 1)
                           + NUM_BITS'(dabs_reg[5]);
            den_reg[6]  <= {dabs_reg[5], 1'b0};
            negx_reg[6] <= px_reg[PR_BITS-1] ^ dneg_reg[5];
            negy_reg[6] <= py_reg[PR_BITS-1] ^ dneg_reg[5];
            qx_reg[6]   <= '0;
            qy_reg[6]   <= '0;
        end
    end

    // restoring divider, one quotient bit per stage, msb first
    for (genvar j = 0; j < QUO_BITS; j++)
    begin : g_div
        localparam int S = DIV_FIRST + j;
        logic [NUM_BITS-1:0] shd;
        logic                gex, gey;

        assign shd = NUM_BITS'(den_reg[S-1]) << (QUO_BITS - 1 - j);
        assign gex = remx_reg[S-1] >= shd;
        assign gey = remy_reg[S-1] >= shd;

        always_ff @(posedge clk)
        begin
            if (en[S])
            begin
                remx_reg[S] <= gex ? remx_reg[S-1] - shd : remx_reg[S-1];
                remy_reg[S] <= gey ? remy_reg[S-1] - shd : remy_reg[S-1];
                qx_reg[S]   <= {qx_reg[S-1][QUO_BITS-2:0], gex};
                qy_reg[S]   <= {qy_reg[S-1][QUO_BITS-2:0], gey};
                den_reg[S]  <= den_reg[S-1];
                negx_reg[S] <= negx_reg[S-1];
                negy_reg[S] <= negy_reg[S-1];
            end
        end
    end

    always_comb
    begin
        logic signed [COORD_BITS+1:0] xs, ys, qxs, qys, sx, sy;
        xs  = (COORD_BITS+2)'(x1_reg[DIV_LAST]);
        ys  = (COORD_BITS+2)'(y1_reg[DIV_LAST]);
        qxs = $signed({1'b0, qx_reg[DIV_LAST]});
        qys = $signed({1'b0, qy_reg[DIV_LAST]});
        sx  = negx_reg[DIV_LAST] ? xs - qxs : xs + qxs;
        sy  = negy_reg[DIV_LAST] ? ys - qys : ys + qys;
        if (stat_reg[DIV_LAST] == STAT_CROSS)
        begin
            cross_x_next = sx[COORD_BITS-1:0];
            cross_y_next = sy[COORD_BITS-1:0];
        end
        else
        begin
            cross_x_next = '0;
            cross_y_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES])
        begin
            cross_x_reg      <= cross_x_next;
            cross_y_reg      <= cross_y_next;
            cross_status_reg <= stat_reg[DIV_LAST];
        end
    end

    assign out_valid    = vld_reg[NUM_STAGES];
    assign cross_x      = cross_x_reg;
    assign cross_y      = cross_y_reg;
    assign cross_status = cross_status_reg;

endmodule

>>> src/segx_checker.sv
// Port-level checks for the segment crossing core, with bind.
module segx_checker
    import segx_pkg::*;
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic signed [COORD_BITS-1:0] cross_x,
    input logic signed [COORD_BITS-1:0] cross_y,
    input logic [1:0]                   cross_status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(cross_x) && $stable(cross_y)
                                    && $stable(cross_status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cross_status != 2'd3)
        else $error("status three produced");

    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (cross_status == STAT_PARALLEL || cross_status == STAT_OUTSIDE)
        |-> cross_x == '0 && cross_y == '0)
        else $error("point nonzero without crossing");

endmodule

bind segment_intersection_core segx_checker u_segx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cross_x      (cross_x),
    .cross_y      (cross_y),
    .cross_status (cross_status)
);
